// ----- rtl/nur_pkg.sv -----
// ----------------------------------------------------------------------------
// nur_pkg: shared definitions for the NUR replacement block
// Operation codes, field widths, register map and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package nur_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 16;

   localparam int OP_W    = 2;
   localparam int INDEX_W = 4;
   localparam int CLASS_W = 2;
   localparam int COUNT_W = 16;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [OP_W-1:0] OP_READ       = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE      = 2'd1;
   localparam logic [OP_W-1:0] OP_REPLACE    = 2'd2;
   localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd3;

   // Worst class plus one, used to seed the minimum search.
   localparam logic [CLASS_W:0] CLASS_NONE = 3'd4;

   typedef struct packed {
      logic access;      // count an access and set R on the addressed block
      logic write;       // with access: also set M
      logic invalidate;  // clear all flags and the counter
      logic load_zero;   // load an all-zero result into the output register
      logic scan_start;  // reset the scan index and the search registers
      logic scan_step;   // examine one block header
      logic commit;      // load the victim result and claim the block
   } cmd_type;

   typedef struct packed {
      logic scan_last;   // scan index points at the last block
   } status_type;

endpackage

// ----- rtl/nur_cache_replacement.sv -----
// ----------------------------------------------------------------------------
// nur_cache_replacement: not-recently-used victim selection
// Tracks valid, referenced and modified bits per cache block and picks a
// replacement victim on request.
//
//   Channel | Direction | Content
//   req_    | in        | tdata[1:0] operation, tdata[5:2] block_index
//   rsp_    | out       | tdata[3:0] victim_index, [4] was_free, [6:5] class
//   csr_    | in/out    | register 0 at byte 0: clear_interval[15:0]
//
// Read, write and invalidate items load their result into the output
// register at acceptance.
// A replace request runs the header scan, which examines one block per cycle.
// The next item is accepted once no replace scan runs and the output register is empty or being taken.
// Synchronous reset clears all block flags, the access counter and the
// interval register; no clearing pass follows.
// ----------------------------------------------------------------------------
module nur_cache_replacement
   import nur_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [1:0] operation, [5:2] block_index
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] victim_index, [4] victim_was_free,
                                              // [6:5] victim_class
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cmd_type            cmd;
   status_type         status;
   logic [OP_W-1:0]    req_operation;
   logic [INDEX_W-1:0] req_block_index;
   logic [INDEX_W-1:0] rsp_victim_index;
   logic               rsp_victim_was_free;
   logic [CLASS_W-1:0] rsp_victim_class;
   logic [COUNT_W-1:0] clear_interval_ff, clear_interval_in;
   logic               csr_write;

   assign req_operation   = req_tdata[OP_W-1:0];
   assign req_block_index = req_tdata[OP_W+INDEX_W-1:OP_W];

   assign rsp_tdata = {1'b0, rsp_victim_class, rsp_victim_was_free, rsp_victim_index};

   // A single register: every address within the port decodes to it.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_ADDR_W-1:0] == csr_paddr);
   assign csr_prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, clear_interval_ff};

   assign clear_interval_in = csr_write ? csr_pwdata[COUNT_W-1:0] : clear_interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_interval_ff <= '0;
      end else begin
         clear_interval_ff <= clear_interval_in;
      end
   end

   nur_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_operation),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   nur_dpath #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_block_index     (req_block_index),
      .clear_interval      (clear_interval_ff),
      .rsp_victim_index    (rsp_victim_index),
      .rsp_victim_was_free (rsp_victim_was_free),
      .rsp_victim_class    (rsp_victim_class)
   );

endmodule

// ----- rtl/nur_ctrl.sv -----
// ----------------------------------------------------------------------------
// nur_ctrl: sequencing for the NUR replacement block
// Accepts items, steps the header scan of a replace request and owns the
// valid flag of the output register.
// ----------------------------------------------------------------------------
module nur_ctrl
   import nur_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [OP_W-1:0] req_op,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  status_type      status,
   output cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       slot_free;
   logic       accept;
   logic       load;

   assign slot_free  = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op) inside
                  OP_READ, OP_WRITE: begin
                     cmd.access    = 1'b1;
                     cmd.write     = (req_op == OP_WRITE);
                     cmd.load_zero = 1'b1;
                  end
                  OP_REPLACE: begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  default: begin
                     cmd.invalidate = 1'b1;
                     cmd.load_zero  = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign load = cmd.load_zero || cmd.commit;

   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_replace_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_REPLACE) |=> !req_tready)
      else $error("input taken while a replace scan runs");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("replace result not presented after commit");

   a_scan_leaves_cleanly: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> (state_ff == ST_SCAN || state_ff == ST_DONE))
      else $error("scan left without reaching the result state");
`endif

endmodule

// ----- rtl/nur_dpath.sv -----
// ----------------------------------------------------------------------------
// nur_dpath: block flags, access counter, header scan and result register
// Holds valid, referenced and modified bits per block, scans one block per
// cycle for a victim and keeps the result until it is taken.
// ----------------------------------------------------------------------------
module nur_dpath
   import nur_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [INDEX_W-1:0] req_block_index,
   input  logic [COUNT_W-1:0] clear_interval,
   output logic [INDEX_W-1:0] rsp_victim_index,
   output logic               rsp_victim_was_free,
   output logic [CLASS_W-1:0] rsp_victim_class
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

   logic [NUM_BLOCKS-1:0] valid_ff, valid_in;
   logic [NUM_BLOCKS-1:0] ref_ff, ref_in;
   logic [NUM_BLOCKS-1:0] mod_ff, mod_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [CLASS_W:0]   best_class_ff, best_class_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;

   logic [INDEX_W-1:0] victim_index_ff, victim_index_in;
   logic               victim_free_ff, victim_free_in;
   logic [CLASS_W-1:0] victim_class_ff, victim_class_in;

   logic [COUNT_W-1:0] count_inc;
   logic               clear_ref;
   logic               in_range;
   logic [IDX_W-1:0]   access_idx;
   logic [CLASS_W-1:0] scan_class;
   logic [IDX_W-1:0]   victim_idx;

   assign count_inc  = count_ff + COUNT_W'(1);
   assign clear_ref  = (clear_interval != '0) && (count_inc >= clear_interval);
   assign in_range   = (32'(req_block_index) < NUM_BLOCKS);
   assign access_idx = IDX_W'(req_block_index);
   assign scan_class = {ref_ff[scan_idx_ff], mod_ff[scan_idx_ff]};
   assign victim_idx = free_found_ff ? free_idx_ff : best_idx_ff;

   assign status.scan_last = (scan_idx_ff == LAST_IDX);

   // Flag and counter updates.
   always_comb begin
      valid_in = valid_ff;
      ref_in   = ref_ff;
      mod_in   = mod_ff;
      count_in = count_ff;
      if (cmd.access) begin
         // The periodic clear happens before the new reference is recorded.
         if (clear_ref) begin
            ref_in   = '0;
            count_in = '0;
         end else begin
            count_in = count_inc;
         end
         if (in_range) begin
            ref_in[access_idx] = 1'b1;
            if (cmd.write) begin
               mod_in[access_idx] = 1'b1;
            end
         end
      end
      if (cmd.invalidate) begin
         valid_in = '0;
         ref_in   = '0;
         mod_in   = '0;
         count_in = '0;
      end
      if (cmd.commit) begin
         valid_in[victim_idx] = 1'b1;
         ref_in[victim_idx]   = 1'b0;
         mod_in[victim_idx]   = 1'b0;
      end
   end

   // Victim search, one block header per cycle.
   always_comb begin
      scan_idx_in   = scan_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_class_in = best_class_ff;
      best_idx_in   = best_idx_ff;
      if (cmd.scan_start) begin
         scan_idx_in   = '0;
         free_found_in = 1'b0;
         free_idx_in   = '0;
         best_class_in = CLASS_NONE;
         best_idx_in   = '0;
      end else if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
         if (!valid_ff[scan_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = scan_idx_ff;
         end
         // Strict compare keeps the lowest index among equal classes.
         if ({1'b0, scan_class} < best_class_ff) begin
            best_class_in = {1'b0, scan_class};
            best_idx_in   = scan_idx_ff;
         end
      end
   end

   always_comb begin
      victim_index_in = victim_index_ff;
      victim_free_in  = victim_free_ff;
      victim_class_in = victim_class_ff;
      if (cmd.load_zero) begin
         victim_index_in = '0;
         victim_free_in  = 1'b0;
         victim_class_in = '0;
      end else if (cmd.commit) begin
         victim_index_in = INDEX_W'(victim_idx);
         victim_free_in  = free_found_ff;
         victim_class_in = free_found_ff ? '0 : best_class_ff[CLASS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ref_ff   <= '0;
         mod_ff   <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         ref_ff   <= ref_in;
         mod_ff   <= mod_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff     <= scan_idx_in;
      free_found_ff   <= free_found_in;
      free_idx_ff     <= free_idx_in;
      best_class_ff   <= best_class_in;
      best_idx_ff     <= best_idx_in;
      victim_index_ff <= victim_index_in;
      victim_free_ff  <= victim_free_in;
      victim_class_ff <= victim_class_in;
   end

   assign rsp_victim_index    = victim_index_ff;
   assign rsp_victim_was_free = victim_free_ff;
   assign rsp_victim_class    = victim_class_ff;

`ifndef SYNTHESIS
   a_invalidate_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.invalidate |=> (valid_ff == '0 && ref_ff == '0 && mod_ff == '0))
      else $error("flags not cleared by invalidate");

   a_commit_claims: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (valid_ff != '0))
      else $error("no block valid after a replace");

   a_scan_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |=> (scan_idx_ff == '0 && !free_found_ff))
      else $error("scan did not start from the first block");
`endif

endmodule

// ----- test/nur_victim_checker.sv -----
// ----------------------------------------------------------------------------
// nur_victim_checker: result checker for the NUR replacement block
// Watches the request, result and register ports, keeps its own copy of
// the valid, referenced and modified flags and of the access counter, and
// works out the victim for every accepted request. Each result is compared
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module nur_victim_checker
   import nur_pkg::*;
#(
   parameter int                  NUM_BLOCKS = NUM_BLOCKS_DEFAULT,
   parameter logic [CSR_ADDR_W-1:0] INTERVAL_ADDR = '0
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [1:0] operation, [5:2] block_index
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] victim_index, [4] victim_was_free,
                                              // [6:5] victim_class
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int unsigned           failures,
   output int unsigned           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CLASS_W-1:0] cls;
      logic               was_free;
      logic [INDEX_W-1:0] index;
   } victim_type;

   logic [NUM_BLOCKS-1:0] valid_bits;
   logic [NUM_BLOCKS-1:0] ref_bits;
   logic [NUM_BLOCKS-1:0] mod_bits;
   logic [COUNT_W-1:0]    access_count;
   logic [COUNT_W-1:0]    clear_interval;
   victim_type            victim_q[$];

   initial failures = 0;
   initial pending = 0;

   // Applies one request to the flag copy and returns the result it yields.
   function automatic victim_type predict_victim(logic [OP_W-1:0] op,
                                                 logic [INDEX_W-1:0] blk);
      victim_type res;
      int      i;
      int      pick;
      int      best;
      int      cls;
      bit      found;
      res = '0;
      case (op) inside
         OP_READ, OP_WRITE: begin
            access_count = access_count + 1'b1;
            if (clear_interval != '0 && access_count >= clear_interval) begin
               ref_bits = '0;
               access_count = '0;
            end
            if (blk < NUM_BLOCKS) begin
               ref_bits[blk] = 1'b1;
               if (op == OP_WRITE) mod_bits[blk] = 1'b1;
            end
         end
         OP_REPLACE: begin
            found = 1'b0;
            pick = 0;
            for (i = 0; i < NUM_BLOCKS; i++) begin
               if (!found && !valid_bits[i]) begin
                  found = 1'b1;
                  pick = i;
               end
            end
            if (found) begin
               res.was_free = 1'b1;
            end else begin
               best = 4;
               for (i = 0; i < NUM_BLOCKS; i++) begin
                  cls = 2 * int'(ref_bits[i]) + int'(mod_bits[i]);
                  if (cls < best) begin
                     best = cls;
                     pick = i;
                  end
               end
               res.cls = best[CLASS_W-1:0];
            end
            res.index = pick[INDEX_W-1:0];
            valid_bits[pick] = 1'b1;
            ref_bits[pick] = 1'b0;
            mod_bits[pick] = 1'b0;
         end
         default: begin
            valid_bits = '0;
            ref_bits = '0;
            mod_bits = '0;
            access_count = '0;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      victim_type want;
      if (reset) begin
         valid_bits = '0;
         ref_bits = '0;
         mod_bits = '0;
         access_count = '0;
         clear_interval = '0;
         victim_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == INTERVAL_ADDR) begin
            clear_interval = csr_pwdata[COUNT_W-1:0];
         end
         // The result taken at this edge belongs to an older item than any
         // request accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (victim_q.size() == 0) begin
               $error("result item with no request outstanding: tdata 0x%h", rsp_tdata);
               failures++;
            end else begin
               want = victim_q.pop_front();
               if (rsp_tdata[INDEX_W-1:0] !== want.index) begin
                  $error("victim_index: expected %0d, actual %0d",
                         want.index, rsp_tdata[INDEX_W-1:0]);
                  failures++;
               end
               if (rsp_tdata[INDEX_W] !== want.was_free) begin
                  $error("victim_was_free: expected %0d, actual %0d",
                         want.was_free, rsp_tdata[INDEX_W]);
                  failures++;
               end
               if (rsp_tdata[INDEX_W+1 +: CLASS_W] !== want.cls) begin
                  $error("victim_class: expected %0d, actual %0d",
                         want.cls, rsp_tdata[INDEX_W+1 +: CLASS_W]);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            victim_q.push_back(predict_victim(req_tdata[OP_W-1:0],
                                              req_tdata[OP_W +: INDEX_W]));
         end
      end
      pending = victim_q.size();
   end

endmodule

// ----- test/nur_cache_replacement_tb.sv -----
// ----------------------------------------------------------------------------
// nur_cache_replacement_tb: testbench top for the NUR replacement block
// Drives a short directed sequence and then random request streams under
// several clear intervals, with random idle bursts on both channels and one
// long result stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module nur_cache_replacement_tb;
   import nur_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                    NUM_BLOCKS = NUM_BLOCKS_DEFAULT;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CLEAR_INTERVAL = '0;
   localparam int                    SETTLE = NUM_BLOCKS + 4;
   localparam int                    LONG_HOLD = 300;
   localparam int                    PHASES = 8;
   localparam int                    PHASE_ITEMS = 140;
   localparam int                    CYCLE_LIMIT = 400000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // [1:0] operation, [5:2] block_index
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [3:0] victim_index, [4] victim_was_free,
                                             // [6:5] victim_class
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned failures;
   int unsigned pending;
   int unsigned cycle_count = 0;
   bit          steady = 1'b0;
   bit          hold_request = 1'b0;

   nur_cache_replacement #(.NUM_BLOCKS(NUM_BLOCKS)) dut (.*);

   nur_victim_checker #(
      .NUM_BLOCKS   (NUM_BLOCKS),
      .INTERVAL_ADDR(ADDR_CLEAR_INTERVAL)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_pready (csr_pready),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side: ready stretches, random stall bursts and one long hold-off.
   initial begin : receiver
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] blk);
      req_tdata <= {{(REQ_DATA_W-OP_W-INDEX_W){1'b0}}, blk, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Returns once every predicted result has arrived and the block has had
   // time to finish any scan still under way.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
         while (pending != 0) @(posedge clock);
         repeat (SETTLE) @(posedge clock);
      end while (pending != 0);
   endtask

   initial begin : stimulus
      int          phase;
      int          n;
      int          i;
      int unsigned pick;
      logic [COUNT_W-1:0] interval;
      logic [OP_W-1:0]    op;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_write(ADDR_CLEAR_INTERVAL, '0);

      // Accesses to invalid blocks at both ends, then fill every block
      // through free-slot replacement.
      send_item(OP_READ, 4'd0);
      send_item(OP_WRITE, 4'd15);
      for (i = 0; i < NUM_BLOCKS; i++) send_item(OP_REPLACE, 4'd0);
      // With all blocks valid, the lowest untouched block wins at class zero.
      send_item(OP_WRITE, 4'd3);
      send_item(OP_READ, 4'd5);
      send_item(OP_WRITE, 4'd0);
      send_item(OP_REPLACE, 4'd9);
      send_item(OP_INVALIDATE, 4'd15);
      send_item(OP_REPLACE, 4'd0);
      wait_idle();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: interval = 16'd0;
            1: interval = 16'd1;
            2: interval = 16'd65535;
            3: interval = 16'd3;
            4: interval = 16'($urandom_range(2, 40));
            5: interval = 16'd16;
            6: interval = 16'($urandom_range(0, 65535));
            default: interval = 16'd7;
         endcase
         // Bits above the register width are written at random as well.
         csr_write(ADDR_CLEAR_INTERVAL, {16'($urandom), interval});
         steady = (phase == PHASES - 1);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == 40) hold_request = 1'b1;
            if (!steady && !hold_request && $urandom_range(0, 5) == 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) op = OP_READ;
            else if (pick < 65) op = OP_WRITE;
            else if (pick < 97) op = OP_REPLACE;
            else op = OP_INVALIDATE;
            send_item(op, INDEX_W'($urandom_range(0, 15)));
         end
         wait_idle();
      end

      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
